// ===== sv/rkr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkr_pkg
// Shared types and constants for the common factor key recovery unit.
// ----------------------------------------------------------------------------
package rkr_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_BITS  = 6;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FACTOR = 2'd1,
		ST_NOT_INV   = 2'd2,
		ST_ZERO_DIV  = 2'd3
	} status_t;

	// Operand and destination selects for the shared divider.
	typedef enum logic [1:0] {
		DIV_GCD = 2'd0,
		DIV_Q   = 2'd1,
		DIV_INV = 2'd2
	} div_op_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		div_op_t div_op;
		logic    div_commit;
		logic    phi_mul;
		logic    inv_init;
		logic    finish_fail;
		status_t fail_status;
		logic    finish_ok;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic gcd_b_zero;
		logic gcd_a_zero;
		logic gcd_a_one;
		logic inv_nr_zero;
		logic inv_r_gt1;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/rsa_key_recovery_common_factor_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_key_recovery_common_factor_unit
// Recovers p, q and the private exponent from a block sharing a factor
// with the modulus.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every Euclid round, in the gcd and in
// the inverse, runs one shift-subtract division plus bookkeeping, and the
// cofactor division and phi product come between the two loops. The result
// holds on the output until it is taken, and the next request is accepted
// after that.
module rsa_key_recovery_common_factor_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// modulus [31:0], public_exponent [63:32], known_block [95:64]
	input  wire logic [95:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// factor_p [31:0], factor_q [63:32], private_exponent [95:64],
	// status [97:96], zero [103:98]
	output logic [103:0]      m_tdata
);

	rkr_pkg::cmd_t    cmd;
	rkr_pkg::sts_t    sts;
	rkr_pkg::word_t   res_p, res_q, res_d;
	rkr_pkg::status_t res_status;

	rkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (s_tvalid && s_tready),
		.in_ready  (s_tready),
		.out_fire  (m_tvalid && m_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd),
		.sts       (sts)
	);

	rkr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_n       (s_tdata[31:0]),
		.in_e       (s_tdata[63:32]),
		.in_m       (s_tdata[95:64]),
		.res_p      (res_p),
		.res_q      (res_q),
		.res_d      (res_d),
		.res_status (res_status)
	);

	assign m_tdata = {6'b0, res_status, res_d, res_q, res_p};

endmodule

`default_nettype wire

// ===== sv/rkr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkr_datapath
// Working registers, a radix-2 restoring divider, the phi multiplier and
// the extended Euclid coefficient update.
// ----------------------------------------------------------------------------
module rkr_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rkr_pkg::cmd_t cmd,
	output rkr_pkg::sts_t      sts,
	input  wire rkr_pkg::word_t in_n,
	input  wire rkr_pkg::word_t in_e,
	input  wire rkr_pkg::word_t in_m,
	output rkr_pkg::word_t     res_p,
	output rkr_pkg::word_t     res_q,
	output rkr_pkg::word_t     res_d,
	output rkr_pkg::status_t   res_status
);

	localparam int W = rkr_pkg::WORD_BITS;

	rkr_pkg::word_t n_q, e_q, a_q, b_q, p_q, q_q, phi_q;
	rkr_pkg::word_t r_q, nr_q, mag_q, nmag_q, tm_q;
	logic           k_odd_q, k_nz_q;
	rkr_pkg::word_t dvd_q, dvs_q, quo_q, rem_q;
	logic [rkr_pkg::CNT_BITS-1:0] cnt_q;
	logic           busy_q, done_q, tm_phase_q;
	rkr_pkg::word_t mul_a, mul_b, prod;
	logic [W:0]     trial;
	rkr_pkg::word_t dvd_sel, dvs_sel, rem_sh;

	always_comb begin
		unique case (cmd.div_op)
			rkr_pkg::DIV_GCD: begin
				dvd_sel = a_q;
				dvs_sel = b_q;
			end
			rkr_pkg::DIV_Q: begin
				dvd_sel = n_q;
				dvs_sel = p_q;
			end
			default: begin
				dvd_sel = r_q;
				dvs_sel = nr_q;
			end
		endcase
	end

	assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial  = {rem_q, dvd_q[W-1]} - {1'b0, dvs_q};
	assign mul_a  = tm_phase_q ? quo_q  : p_q - 1'b1;
	assign mul_b  = tm_phase_q ? nmag_q : q_q - 1'b1;
	assign prod   = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			tm_phase_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.div_start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == rkr_pkg::CNT_BITS'(W - 1)) begin
					busy_q     <= 1'b0;
					tm_phase_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (tm_phase_q) begin
				tm_phase_q <= 1'b0;
				done_q     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= in_n;
			e_q <= in_e;
			a_q <= in_m;
			b_q <= in_n;
		end
		if (cmd.div_start) begin
			dvd_q <= dvd_sel;
			dvs_q <= dvs_sel;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (tm_phase_q) begin
			tm_q <= mag_q + prod;
		end
		if (cmd.div_commit) begin
			unique case (cmd.div_op)
				rkr_pkg::DIV_GCD: begin
					a_q <= b_q;
					b_q <= rem_q;
				end
				rkr_pkg::DIV_Q: begin
					q_q <= quo_q;
				end
				default: begin
					mag_q   <= nmag_q;
					nmag_q  <= tm_q;
					r_q     <= nr_q;
					nr_q    <= rem_q;
					k_odd_q <= ~k_odd_q;
					k_nz_q  <= 1'b1;
				end
			endcase
		end
		if (cmd.phi_mul) begin
			p_q <= a_q;
		end
		if (cmd.inv_init) begin
			phi_q   <= prod;
			r_q     <= prod;
			nr_q    <= e_q;
			mag_q   <= '0;
			nmag_q  <= rkr_pkg::word_t'(1);
			k_odd_q <= 1'b0;
			k_nz_q  <= 1'b0;
		end
		if (cmd.finish_fail) begin
			res_status <= cmd.fail_status;
			res_d      <= '0;
			unique case (cmd.fail_status)
				rkr_pkg::ST_ZERO_DIV: begin
					res_p <= '0;
					res_q <= '0;
				end
				rkr_pkg::ST_NO_FACTOR: begin
					res_p <= rkr_pkg::word_t'(1);
					res_q <= n_q;
				end
				default: begin
					res_p <= p_q;
					res_q <= q_q;
				end
			endcase
		end
		if (cmd.finish_ok) begin
			res_status <= rkr_pkg::ST_OK;
			res_p      <= p_q;
			res_q      <= q_q;
			if (k_nz_q && !k_odd_q && mag_q != '0) begin
				res_d <= phi_q - mag_q;
			end else begin
				res_d <= mag_q;
			end
		end
	end

	assign sts.div_done    = done_q;
	assign sts.gcd_b_zero  = (b_q == '0);
	assign sts.gcd_a_zero  = (a_q == '0);
	assign sts.gcd_a_one   = (a_q == rkr_pkg::word_t'(1));
	assign sts.inv_nr_zero = (nr_q == '0);
	assign sts.inv_r_gt1   = (r_q > rkr_pkg::word_t'(1));

endmodule

`default_nettype wire

// ===== sv/rkr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkr_ctrl
// Sequencer: gcd loop, cofactor division, phi product, inverse loop, output.
// ----------------------------------------------------------------------------
module rkr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	output logic               in_ready,
	input  wire logic          out_fire,
	output logic               out_valid,
	output rkr_pkg::cmd_t      cmd,
	input  wire rkr_pkg::sts_t sts
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_GCD   = 9'b000000010,
		S_GDIV  = 9'b000000100,
		S_QDIV  = 9'b000001000,
		S_PHI   = 9'b000010000,
		S_INV   = 9'b000100000,
		S_IDIV  = 9'b001000000,
		S_INIT  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = S_GCD;
				end
			end
			S_GCD: begin
				if (!sts.gcd_b_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = rkr_pkg::DIV_GCD;
					state_d       = S_GDIV;
				end else if (sts.gcd_a_zero) begin
					cmd.finish_fail = 1'b1;
					cmd.fail_status = rkr_pkg::ST_ZERO_DIV;
					state_d         = S_OUT;
				end else if (sts.gcd_a_one) begin
					cmd.finish_fail = 1'b1;
					cmd.fail_status = rkr_pkg::ST_NO_FACTOR;
					state_d         = S_OUT;
				end else begin
					cmd.phi_mul = 1'b1;
					state_d     = S_PHI;
				end
			end
			S_GDIV: begin
				cmd.div_op = rkr_pkg::DIV_GCD;
				if (sts.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = S_GCD;
				end
			end
			S_PHI: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = rkr_pkg::DIV_Q;
				state_d       = S_QDIV;
			end
			S_QDIV: begin
				cmd.div_op = rkr_pkg::DIV_Q;
				if (sts.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = S_INIT;
				end
			end
			S_INIT: begin
				cmd.inv_init = 1'b1;
				state_d      = S_INV;
			end
			S_INV: begin
				cmd.div_op = rkr_pkg::DIV_INV;
				if (!sts.inv_nr_zero) begin
					cmd.div_start = 1'b1;
					state_d       = S_IDIV;
				end else if (sts.inv_r_gt1) begin
					cmd.finish_fail = 1'b1;
					cmd.fail_status = rkr_pkg::ST_NOT_INV;
					state_d         = S_OUT;
				end else begin
					cmd.finish_ok = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_IDIV: begin
				cmd.div_op = rkr_pkg::DIV_INV;
				if (sts.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = S_INV;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_rsa_key_recovery_common_factor_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rsa_key_recovery_common_factor_unit
// Checks factor recovery and private exponent inversion against a local
// model of the gcd, cofactor, phi and extended Euclid steps, under random
// idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_rsa_key_recovery_common_factor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rkr_pkg::word_t   p;
		rkr_pkg::word_t   q;
		rkr_pkg::word_t   d;
		rkr_pkg::status_t st;
	} recovery_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;

	recovery_t pending_q[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	bit        failed;

	rsa_key_recovery_common_factor_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic rkr_pkg::word_t word_gcd_of(rkr_pkg::word_t a, rkr_pkg::word_t b);
		rkr_pkg::word_t r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic recovery_t recover_key(rkr_pkg::word_t n, rkr_pkg::word_t e,
			rkr_pkg::word_t m);
		recovery_t      res;
		rkr_pkg::word_t phi, r, nr, mag, nmag, quo, tm, rem;
		int             k;
		res = '0;
		res.p = word_gcd_of(m, n);
		if (res.p == 0) begin
			res.st = rkr_pkg::ST_ZERO_DIV;
		end else if (res.p == 1) begin
			res.q = n;
			res.st = rkr_pkg::ST_NO_FACTOR;
		end else begin
			res.q = n / res.p;
			phi = (res.p - 1) * (res.q - 1);
			r = phi; nr = e; mag = 0; nmag = 1; k = 0;
			while (nr != 0) begin
				quo = r / nr;
				tm = mag + quo * nmag;
				rem = r - quo * nr;
				mag = nmag; nmag = tm; r = nr; nr = rem;
				k++;
			end
			if (r > 1) begin
				res.st = rkr_pkg::ST_NOT_INV;
			end else begin
				res.st = rkr_pkg::ST_OK;
				res.d = (k != 0 && k % 2 == 0 && mag != 0) ? phi - mag : mag;
			end
		end
		return res;
	endfunction

	task automatic send_request(rkr_pkg::word_t n, rkr_pkg::word_t e, rkr_pkg::word_t m);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		pending_q.push_back(recover_key(n, e, m));
		s_tvalid <= 1'b1;
		s_tdata  <= {m, e, n};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	always @(posedge clk) begin
		recovery_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result beat %h", m_tdata);
				failed = 1;
			end else begin
				exp_r = pending_q.pop_front();
				if (m_tdata[31:0] !== exp_r.p) begin
					$error("factor_p exp %h got %h", exp_r.p, m_tdata[31:0]);
					failed = 1;
				end
				if (m_tdata[63:32] !== exp_r.q) begin
					$error("factor_q exp %h got %h", exp_r.q, m_tdata[63:32]);
					failed = 1;
				end
				if (m_tdata[95:64] !== exp_r.d) begin
					$error("private_exponent exp %h got %h", exp_r.d, m_tdata[95:64]);
					failed = 1;
				end
				if (m_tdata[97:96] !== exp_r.st) begin
					$error("status exp %0d got %0d", exp_r.st, m_tdata[97:96]);
					failed = 1;
				end
			end
		end
	end

	function automatic rkr_pkg::word_t rand_word();
		case ($urandom_range(3, 0))
			0: return $urandom_range(40, 0);
			1: return $urandom_range(4095, 0);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_request(0, 0, 0);
		send_request(0, 17, 12);
		send_request(35, 5, 0);
		send_request(33, 7, 11);
		send_request(35, 11, 8);
		send_request(35, 6, 7);
		send_request(4, 0, 2);
		send_request(6, 0, 3);
		send_request(6, 1, 3);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 65537, 3);
		send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h8000_0000);
		send_request(3233, 17, 61);
		send_request(3233, 17, 53 * 5);
		send_request(32'd4292870399, 65537, 65521);
		send_request(1, 3, 0);
		send_request(0, 32'hFFFF_FFFF, 1);
		send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	task automatic test_random(int count);
		rkr_pkg::word_t p, q, n, e, m;
		repeat (count) begin
			if ($urandom_range(9, 0) < 7) begin
				p = $urandom_range(65535, 2);
				q = $urandom_range(65535, 2);
				n = p * q;
				m = p * $urandom_range(q > 2 ? q - 1 : 1, 1);
				e = ($urandom_range(1, 0)) ? 65537 : ($urandom | 1);
			end else begin
				n = rand_word(); e = rand_word(); m = rand_word();
			end
			send_request(n, e, m);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		failed = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 26; recv_idle_pct = 86;
		test_directed();
		test_random(45);
		send_idle_pct = 86; recv_idle_pct = 26;
		test_random(45);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(45);
		wait_drained();
		if (!failed && pending_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
